// ===== hdl/ymcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// YMODEM CRC receiver package
// Shared payload types, codes and the CRC-16/CCITT byte step.
// ----------------------------------------------------------------------------
package ymcrc_pkg;

    localparam int MAX_FRAME_DEF   = 1040;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int RES_MAX         = 4;

    localparam logic [1:0] FN_BYTE = 2'd0;
    localparam logic [1:0] FN_EOF  = 2'd1;
    localparam logic [1:0] FN_TICK = 2'd2;

    localparam logic [2:0] K_SEND  = 3'd0;
    localparam logic [2:0] K_DATA  = 3'd1;
    localparam logic [2:0] K_VERD  = 3'd2;
    localparam logic [2:0] K_ERASE = 3'd3;
    localparam logic [2:0] K_RESET = 3'd4;

    localparam logic [3:0] S_NEW   = 4'd0;
    localparam logic [3:0] S_DUP   = 4'd1;
    localparam logic [3:0] S_TYPE  = 4'd2;
    localparam logic [3:0] S_LEN   = 4'd3;
    localparam logic [3:0] S_SEQ   = 4'd4;
    localparam logic [3:0] S_CRC   = 4'd5;
    localparam logic [3:0] S_LARGE = 4'd6;
    localparam logic [3:0] S_EOT   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [7:0] C_SOH    = 8'h01;
    localparam logic [7:0] C_STX    = 8'h02;
    localparam logic [7:0] C_EOT    = 8'h04;
    localparam logic [7:0] C_ACK    = 8'h06;
    localparam logic [7:0] C_NAK    = 8'h15;
    localparam logic [7:0] C_PROMPT = 8'h43;

    localparam logic [1:0] BT_NONE = 2'd0;
    localparam logic [1:0] BT_SOH  = 2'd1;
    localparam logic [1:0] BT_STX  = 2'd2;
    localparam logic [1:0] BT_EOT  = 2'd3;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_POLL   = 2'd1;
    localparam logic [1:0] REG_MAXSZ  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  out_byte;
        logic [23:0] out_offset;
        logic [10:0] out_length;
        logic [3:0]  out_status;
        logic        out_last;
    } out_item_t;

    // one frontend decision: up to four results
    typedef struct packed {
        logic [2:0] count;
        out_item_t  r0;
        out_item_t  r1;
        out_item_t  r2;
        out_item_t  r3;
    } res_group_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    function automatic out_item_t mk(input logic [2:0] k, input logic [7:0] b,
                                     input logic [23:0] o, input logic [10:0] l,
                                     input logic [3:0] s);
        out_item_t r;
        r.out_kind   = k;
        r.out_byte   = b;
        r.out_offset = o;
        r.out_length = l;
        r.out_status = s;
        r.out_last   = 1'b0;
        return r;
    endfunction

endpackage

// ===== hdl/ymodem_crc_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// YMODEM CRC packet receiver
// Receives YMODEM frames, checks them and issues replies and flash actions.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one event per transaction: a
// received byte, an end-of-frame mark or a timer tick. The output channel
// out_valid/out_stall carries result transactions; out_last marks the final
// result of one event. Events that give no result produce nothing.
// An event's result group is written into the group queue at the edge that
// takes the event, and the back end offers its results from the queue head.
// Throughput: one event per cycle while in_stall is low; results leave at one
// per cycle while out_stall is low, and a group of up to four results leaves
// the queue with its last result. A four-entry group queue sits between the
// front end and the output side; in_stall rises when it is full, so output stalls back up to the input.
// Configuration goes through the APB port: enable at 0x0, poll_ticks at
// 0x4, max_file_size at 0x8. Reset clears all state to waiting for the
// header with enable off, poll_ticks 40 and max_file_size 131072.
// ----------------------------------------------------------------------------
module ymodem_crc_packet_receiver #(
    parameter int MAX_FRAME   = ymcrc_pkg::MAX_FRAME_DEF,
    parameter int OFFSET_BITS = ymcrc_pkg::OFFSET_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ymcrc_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ymcrc_pkg::out_item_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic        enable_reg;
    logic [15:0] poll_reg;
    logic [23:0] maxsz_reg;
    logic        wr;
    logic        go;
    logic        push;
    logic        empty;
    logic        full;
    logic        pop;
    ymcrc_pkg::res_group_t grp;
    ymcrc_pkg::res_group_t head;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            ymcrc_pkg::REG_ENABLE: prdata = {31'd0, enable_reg};
            ymcrc_pkg::REG_POLL:   prdata = {16'd0, poll_reg};
            ymcrc_pkg::REG_MAXSZ:  prdata = {8'd0, maxsz_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            poll_reg   <= 16'd40;
            maxsz_reg  <= 24'd131072;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                ymcrc_pkg::REG_ENABLE: enable_reg <= pwdata[0];
                ymcrc_pkg::REG_POLL:   poll_reg   <= pwdata[15:0];
                ymcrc_pkg::REG_MAXSZ:  maxsz_reg  <= pwdata[23:0];
                default:               enable_reg <= enable_reg;
            endcase
        end
    end

    assign in_stall = full;
    assign go       = in_valid && !in_stall;
    assign push     = (grp.count != 3'd0);

    ymcrc_front #(
        .MAX_FRAME   (MAX_FRAME),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (go),
        .item          (in_data),
        .enable        (enable_reg),
        .poll_ticks    (poll_reg),
        .max_file_size (maxsz_reg),
        .grp           (grp)
    );

    ymcrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (grp),
        .pop       (pop),
        .empty     (empty),
        .full      (full),
        .head      (head)
    );

    ymcrc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .head  (head),
        .pop   (pop),
        .valid (out_valid),
        .stall (out_stall),
        .data  (out_data)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("group pushed into full queue");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.out_last) |-> pop)
        else $error("last result did not retire group");

    a_empty_novalid: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !out_valid)
        else $error("output valid with empty queue");

endmodule

// ===== hdl/ymcrc_front.sv =====
// ----------------------------------------------------------------------------
// YMODEM CRC receiver front end
// Accepts events, tracks the frame and protocol state, emits result groups.
// ----------------------------------------------------------------------------
module ymcrc_front #(
    parameter int MAX_FRAME   = ymcrc_pkg::MAX_FRAME_DEF,
    parameter int OFFSET_BITS = ymcrc_pkg::OFFSET_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  ymcrc_pkg::in_item_t   item,
    input  logic                  enable,
    input  logic [15:0]           poll_ticks,
    input  logic [23:0]           max_file_size,
    output ymcrc_pkg::res_group_t grp
);

    localparam int FCW = $clog2(MAX_FRAME + 2);

    typedef enum logic [5:0] {
        ST_HDR  = 6'b000001,
        ST_DATA = 6'b000010,
        ST_EOT2 = 6'b000100,
        ST_FIN  = 6'b001000,
        ST_RSTW = 6'b010000,
        ST_IDLE = 6'b100000
    } stage_t;

    stage_t                 stage_reg, stage_next;
    logic [7:0]             exp_seq_reg, exp_seq_next;
    logic [FCW-1:0]         fcnt_reg, fcnt_next;
    logic [1:0]             btype_reg, btype_next;
    logic [7:0]             seqb_reg, seqb_next;
    logic                   seqok_reg, seqok_next;
    logic [15:0]            crc_reg, crc_next;
    logic [15:0]            crcrx_reg, crcrx_next;
    logic [23:0]            size_reg, size_next;
    logic [1:0]             named_reg, named_next;
    logic [OFFSET_BITS-1:0] woff_reg, woff_next;
    logic [15:0]            tick_reg, tick_next;

    logic [10:0]            dlen;
    logic [11:0]            p;
    logic [7:0]             b;
    logic [27:0]            smul;
    logic [15:0]            pt;
    logic [15:0]            tick_inc;
    logic                   crc_good;
    logic                   seq0;
    logic [OFFSET_BITS-1:0] poff;
    logic                   fin;

    assign fin = (stage_reg == ST_FIN);
    assign b   = item.rx_byte;
    assign p   = 12'(fcnt_reg);

    always_comb
    begin
        case (btype_reg)
            ymcrc_pkg::BT_SOH: dlen = 11'd128;
            ymcrc_pkg::BT_STX: dlen = fin ? 11'd128 : 11'd1024;
            default:           dlen = 11'd0;
        endcase
    end

    assign crc_good = (crc_reg == crcrx_reg);
    assign seq0     = (seqb_reg == 8'd0) && seqok_reg;
    assign smul     = 28'(size_reg) * 28'd10 + 28'(b - 8'h30);
    assign pt       = (poll_ticks == 16'd0) ? 16'd1 : poll_ticks;
    assign tick_inc = tick_reg + 16'd1;
    assign poff     = woff_reg + OFFSET_BITS'(p - 12'd3);

    always_comb
    begin
        stage_next   = stage_reg;
        exp_seq_next = exp_seq_reg;
        fcnt_next    = fcnt_reg;
        btype_next   = btype_reg;
        seqb_next    = seqb_reg;
        seqok_next   = seqok_reg;
        crc_next     = crc_reg;
        crcrx_next   = crcrx_reg;
        size_next    = size_reg;
        named_next   = named_reg;
        woff_next    = woff_reg;
        tick_next    = tick_reg;
        grp          = '0;

        if (go && enable)
        begin
            case (item.func)
                ymcrc_pkg::FN_BYTE:
                begin
                    if (stage_reg != ST_RSTW && stage_reg != ST_IDLE
                        && p <= 12'(MAX_FRAME))
                    begin
                        fcnt_next = FCW'(p + 12'd1);
                        if (p == 12'(MAX_FRAME))
                        begin
                            fcnt_next = FCW'(p + 12'd1);
                        end
                        else if (p == 12'd0)
                        begin
                            btype_next = (b == ymcrc_pkg::C_SOH) ? ymcrc_pkg::BT_SOH :
                                         (b == ymcrc_pkg::C_STX) ? ymcrc_pkg::BT_STX :
                                         (b == ymcrc_pkg::C_EOT) ? ymcrc_pkg::BT_EOT :
                                                                   ymcrc_pkg::BT_NONE;
                        end
                        else if (p == 12'd1)
                        begin
                            seqb_next = b;
                        end
                        else if (p == 12'd2)
                        begin
                            seqok_next = (b == (8'hFF - seqb_reg));
                        end
                        else if (p < 12'd3 + 12'(dlen))
                        begin
                            crc_next = ymcrc_pkg::crc_step(crc_reg, b);
                            if (stage_reg == ST_HDR)
                            begin
                                if (named_reg == 2'd0)
                                begin
                                    if (b == 8'd0)
                                    begin
                                        named_next = 2'd1;
                                    end
                                end
                                else if (named_reg == 2'd1)
                                begin
                                    if (b >= 8'h30 && b <= 8'h39)
                                    begin
                                        size_next = (smul > 28'hFFFFFF) ? 24'hFFFFFF
                                                                        : smul[23:0];
                                    end
                                    else
                                    begin
                                        named_next = 2'd2;
                                    end
                                end
                            end
                            if (stage_reg == ST_DATA)
                            begin
                                grp.count = 3'd1;
                                grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_DATA, b,
                                                       24'(poff), 11'd0, 4'd0);
                            end
                        end
                        else if (p == 12'd3 + 12'(dlen))
                        begin
                            crcrx_next = {b, 8'h00};
                        end
                        else if (p == 12'd4 + 12'(dlen))
                        begin
                            crcrx_next = {crcrx_reg[15:8], b};
                        end
                    end
                end
                ymcrc_pkg::FN_EOF:
                begin
                    if (stage_reg != ST_RSTW && stage_reg != ST_IDLE && p != 12'd0)
                    begin
                        case (stage_reg)
                            ST_HDR:
                            begin
                                grp.count = 3'd1;
                                if (dlen == 11'd0)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_TYPE);
                                end
                                else if (p < 12'd5 + 12'(dlen))
                                begin
                                    grp.count = 3'd2;
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_LEN);
                                    grp.r1 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_NAK, 24'd0,
                                                           11'd0, 4'd0);
                                end
                                else if (!seq0)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_SEQ);
                                end
                                else if (!crc_good)
                                begin
                                    grp.count = 3'd2;
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_CRC);
                                    grp.r1 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_NAK, 24'd0,
                                                           11'd0, 4'd0);
                                end
                                else if (size_reg > max_file_size)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_LARGE);
                                end
                                else
                                begin
                                    grp.count = 3'd4;
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_ERASE, 8'd0, 24'd0,
                                                           11'd0, 4'd0);
                                    grp.r1 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_NEW);
                                    grp.r2 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_ACK, 24'd0,
                                                           11'd0, 4'd0);
                                    grp.r3 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_PROMPT, 24'd0,
                                                           11'd0, 4'd0);
                                    woff_next    = '0;
                                    exp_seq_next = 8'd1;
                                    tick_next    = 16'd0;
                                    stage_next   = ST_DATA;
                                end
                            end
                            ST_DATA:
                            begin
                                grp.count = 3'd2;
                                grp.r1 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND, ymcrc_pkg::C_NAK,
                                                       24'd0, 11'd0, 4'd0);
                                if (btype_reg == ymcrc_pkg::BT_EOT)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_EOT);
                                    stage_next = ST_EOT2;
                                end
                                else if (dlen == 11'd0)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_TYPE);
                                end
                                else if (p != 12'd5 + 12'(dlen))
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_LEN);
                                end
                                else if (!seqok_reg)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_SEQ);
                                end
                                else if (!crc_good)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_CRC);
                                end
                                else if (seqb_reg == exp_seq_reg)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0,
                                                           24'(woff_reg), dlen,
                                                           ymcrc_pkg::S_NEW);
                                    grp.r1 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_ACK, 24'd0,
                                                           11'd0, 4'd0);
                                    woff_next    = woff_reg + OFFSET_BITS'(dlen);
                                    exp_seq_next = exp_seq_reg + 8'd1;
                                end
                                else
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_DUP);
                                    grp.r1 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_ACK, 24'd0,
                                                           11'd0, 4'd0);
                                end
                            end
                            ST_EOT2:
                            begin
                                if (btype_reg == ymcrc_pkg::BT_EOT)
                                begin
                                    grp.count = 3'd3;
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_EOT);
                                    grp.r1 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_ACK, 24'd0,
                                                           11'd0, 4'd0);
                                    grp.r2 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_PROMPT, 24'd0,
                                                           11'd0, 4'd0);
                                    stage_next = ST_FIN;
                                end
                                else
                                begin
                                    grp.count = 3'd2;
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_TYPE);
                                    grp.r1 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_NAK, 24'd0,
                                                           11'd0, 4'd0);
                                end
                            end
                            default:
                            begin
                                grp.count = 3'd1;
                                if (dlen == 11'd0)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_TYPE);
                                end
                                else if (p < 12'd133)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_LEN);
                                end
                                else if (!seq0)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_SEQ);
                                end
                                else if (!crc_good)
                                begin
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_CRC);
                                end
                                else
                                begin
                                    grp.count = 3'd2;
                                    grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_VERD, 8'd0, 24'd0,
                                                           11'd0, ymcrc_pkg::S_DONE);
                                    grp.r1 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                           ymcrc_pkg::C_ACK, 24'd0,
                                                           11'd0, 4'd0);
                                    stage_next = ST_RSTW;
                                    tick_next  = 16'd0;
                                end
                            end
                        endcase
                    end
                    fcnt_next  = '0;
                    btype_next = ymcrc_pkg::BT_NONE;
                    seqb_next  = 8'd0;
                    seqok_next = 1'b0;
                    crc_next   = 16'd0;
                    crcrx_next = 16'd0;
                    size_next  = 24'd0;
                    named_next = 2'd0;
                end
                ymcrc_pkg::FN_TICK:
                begin
                    if (stage_reg == ST_HDR || stage_reg == ST_RSTW)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= pt)
                        begin
                            tick_next = 16'd0;
                            grp.count = 3'd1;
                            if (stage_reg == ST_HDR)
                            begin
                                grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_SEND,
                                                       ymcrc_pkg::C_PROMPT, 24'd0,
                                                       11'd0, 4'd0);
                            end
                            else
                            begin
                                grp.r0 = ymcrc_pkg::mk(ymcrc_pkg::K_RESET, 8'd0, 24'd0,
                                                       11'd0, 4'd0);
                                stage_next = ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    grp.count = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= ST_HDR;
            exp_seq_reg <= 8'd0;
            fcnt_reg    <= '0;
            btype_reg   <= ymcrc_pkg::BT_NONE;
            seqb_reg    <= 8'd0;
            seqok_reg   <= 1'b0;
            crc_reg     <= 16'd0;
            crcrx_reg   <= 16'd0;
            size_reg    <= 24'd0;
            named_reg   <= 2'd0;
            woff_reg    <= '0;
            tick_reg    <= 16'd0;
        end
        else
        begin
            stage_reg   <= stage_next;
            exp_seq_reg <= exp_seq_next;
            fcnt_reg    <= fcnt_next;
            btype_reg   <= btype_next;
            seqb_reg    <= seqb_next;
            seqok_reg   <= seqok_next;
            crc_reg     <= crc_next;
            crcrx_reg   <= crcrx_next;
            size_reg    <= size_next;
            named_reg   <= named_next;
            woff_reg    <= woff_next;
            tick_reg    <= tick_next;
        end
    end

endmodule

// ===== hdl/ymcrc_queue.sv =====
// ----------------------------------------------------------------------------
// YMODEM CRC receiver result queue
// Holds result groups between front end and back end.
// ----------------------------------------------------------------------------
module ymcrc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ymcrc_pkg::res_group_t push_data,
    input  logic                  pop,
    output logic                  empty,
    output logic                  full,
    output ymcrc_pkg::res_group_t head
);

    ymcrc_pkg::res_group_t mem_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == 3'd0);
    assign full  = (cnt_reg == 3'd4);
    assign head  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 2'd1 : wp_reg;
        rp_next  = pop ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/ymcrc_back.sv =====
// ----------------------------------------------------------------------------
// YMODEM CRC receiver back end
// Sends the results of each group, one transaction per cycle while stall is low.
// ----------------------------------------------------------------------------
module ymcrc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  ymcrc_pkg::res_group_t head,
    output logic                  pop,
    output logic                  valid,
    input  logic                  stall,
    output ymcrc_pkg::out_item_t  data
);

    logic [1:0] idx_reg, idx_next;
    logic       last;

    assign valid = !empty;
    assign last  = ({1'b0, idx_reg} + 3'd1) == head.count;

    always_comb
    begin
        case (idx_reg)
            2'd0:    data = head.r0;
            2'd1:    data = head.r1;
            2'd2:    data = head.r2;
            default: data = head.r3;
        endcase
        data.out_last = last;
    end

    assign pop = valid && !stall && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (valid && !stall)
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule
